FILE: hdl/cpi_pkg.sv
`default_nettype none

package cpi_pkg;

    localparam int CHAN_W  = 8;
    localparam int COLOR_W = 3 * CHAN_W;
    localparam int LABEL_W = 8;
    localparam int USED_W  = 9;
    localparam int LIMIT_W = 9;

    // reset value of the palette limit register
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

    // pixel as it travels down the cell chain
    typedef struct packed {
        logic [COLOR_W-1:0] color;     // red, green, blue from msb down
        logic               first;     // palette is emptied ahead of this pixel
        logic               done;      // label already settled upstream
        logic [LABEL_W-1:0] label;
        logic               added;
        logic               ovf;
    } pix_tok_t;

endpackage

`default_nettype wire

FILE: hdl/cpi_ifs.sv
`default_nettype none

interface cpi_pixel_if;
    import cpi_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic              first_pixel;

    modport source (output valid, output blue, output green, output red,
                    output first_pixel, input ready);
    modport sink   (input valid, input blue, input green, input red,
                    input first_pixel, output ready);
endinterface

interface cpi_label_if;
    import cpi_pkg::*;

    logic               valid;
    logic               ready;
    logic [LABEL_W-1:0] label;
    logic               new_entry;
    logic               overflow;
    logic [USED_W-1:0]  colors_used;

    modport source (output valid, output label, output new_entry, output overflow,
                    output colors_used, input ready);
    modport sink   (input valid, input label, input new_entry, input overflow,
                    input colors_used, output ready);
endinterface

`default_nettype wire

FILE: hdl/color_palette_indexer_unit.sv
// Exact color palette indexer.
// pix (sink): one pixel per transfer, blue/green/red bytes in raster order;
//   first_pixel empties the palette before that pixel is looked up.
// lbl (source): one result per pixel, in pixel order: the palette index of
//   the lowest entry equal to the pixel, or a new entry appended at the end;
//   overflow with label 0 when a new color finds the palette at its limit.
// cfg_we / cfg_wdata: palette limit register, to be written only while the
// block idles; the block itself does not enforce this. The palette is a row
// of MAX_COLORS cells, one entry each; a pixel moves one cell per cycle while
// the chain advances, the last cell feeds the result register, and a new
// pixel is taken every cycle in which the chain advances.
// The chain length MAX_COLORS sets the latency; an entry appended by one pixel
// is in its cell before the next pixel reaches that cell.
// Reset empties every cell, clears results in flight and sets the limit to
// 256. When lbl is stalled with a result waiting, the chain keeps shifting
// while its last cell is empty and freezes once a second result is ready.
`default_nettype none

module color_palette_indexer_unit #(
    parameter int MAX_COLORS = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    cpi_pixel_if.sink       pix,
    cpi_label_if.source     lbl,
    input  wire logic       cfg_we,
    input  wire logic [8:0] cfg_wdata
);
    import cpi_pkg::*;

    localparam int CNT_W = $clog2(MAX_COLORS + 1);

    logic [LIMIT_W-1:0] limit_reg;
    logic               advance;
    logic               chain_valid [MAX_COLORS+1];
    pix_tok_t           chain_tok   [MAX_COLORS+1];
    logic [CNT_W-1:0]   chain_cnt   [MAX_COLORS+1];
    logic               out_valid_reg;
    logic [LABEL_W-1:0] out_label_reg;
    logic               out_new_reg;
    logic               out_ovf_reg;
    logic [USED_W-1:0]  out_used_reg;
    pix_tok_t           tail;

    // palette limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    // chain shifts unless a finished pixel would overwrite a waiting result
    assign advance   = !chain_valid[MAX_COLORS] || !out_valid_reg || lbl.ready;
    assign pix.ready = advance;

    // pixel entering the first cell
    always_comb
    begin
        chain_valid[0]       = pix.valid;
        chain_tok[0].color   = {pix.red, pix.green, pix.blue};
        chain_tok[0].first   = pix.first_pixel;
        chain_tok[0].done    = 1'b0;
        chain_tok[0].label   = '0;
        chain_tok[0].added   = 1'b0;
        chain_tok[0].ovf     = 1'b0;
        chain_cnt[0]         = '0;
    end

    // row of palette cells
    for (genvar k = 0; k < MAX_COLORS; k++)
    begin : g_cell
        cpi_cell #(
            .INDEX (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .advance       (advance),
            .limit         (limit_reg),
            .tok_valid     (chain_valid[k]),
            .tok_in        (chain_tok[k]),
            .cnt_in        (chain_cnt[k]),
            .tok_valid_out (chain_valid[k+1]),
            .tok_out       (chain_tok[k+1]),
            .cnt_out       (chain_cnt[k+1])
        );
    end

    assign tail = chain_tok[MAX_COLORS];

    // result register; a pixel unsettled at the end found the palette full
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && chain_valid[MAX_COLORS])
        begin
            out_valid_reg <= 1'b1;
        end
        else if (lbl.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && chain_valid[MAX_COLORS])
        begin
            out_label_reg <= tail.done ? tail.label : '0;
            out_new_reg   <= tail.added;
            out_ovf_reg   <= tail.ovf || !tail.done;
            out_used_reg  <= USED_W'(chain_cnt[MAX_COLORS]);
        end
    end

    assign lbl.valid       = out_valid_reg;
    assign lbl.label       = out_label_reg;
    assign lbl.new_entry   = out_new_reg;
    assign lbl.overflow    = out_ovf_reg;
    assign lbl.colors_used = out_used_reg;

endmodule

`default_nettype wire

FILE: hdl/cpi_cell.sv
`default_nettype none

module cpi_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 9
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic [8:0]        limit,
    input  wire logic              tok_valid,
    input  wire cpi_pkg::pix_tok_t tok_in,
    input  wire logic [CNT_W-1:0]  cnt_in,
    output logic                   tok_valid_out,
    output cpi_pkg::pix_tok_t      tok_out,
    output logic [CNT_W-1:0]       cnt_out
);
    import cpi_pkg::*;

    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam logic [LABEL_W-1:0] MY_LABEL = LABEL_W'(INDEX);
    localparam logic [CMP_W-1:0]   MY_INDEX = CMP_W'(INDEX);

    logic [COLOR_W-1:0] entry_reg;
    logic               used_reg;
    logic               used_next;
    logic               live;
    logic               match;
    logic               room;
    logic               take;
    logic               refuse;
    logic               tok_valid_reg;
    pix_tok_t           tok_reg;
    pix_tok_t           tok_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;

    // compare against the stored entry, append at the first empty cell
    always_comb
    begin
        live   = used_reg && !tok_in.first;
        match  = live && (entry_reg == tok_in.color);
        room   = MY_INDEX < CMP_W'(limit);
        take   = tok_valid && !tok_in.done && !live && room;
        refuse = tok_valid && !tok_in.done && !live && !room;

        tok_next = tok_in;
        if (!tok_in.done && match)
        begin
            tok_next.done  = 1'b1;
            tok_next.label = MY_LABEL;
        end
        if (take)
        begin
            tok_next.done  = 1'b1;
            tok_next.label = MY_LABEL;
            tok_next.added = 1'b1;
        end
        if (refuse)
        begin
            tok_next.done  = 1'b1;
            tok_next.label = '0;
            tok_next.ovf   = 1'b1;
        end

        // used cells form a prefix, so counting them gives the palette size
        used_next = take || live;
        cnt_next  = cnt_in + CNT_W'(used_next);
    end

    // cell control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            tok_valid_reg <= tok_valid;
            if (tok_valid)
            begin
                used_reg <= used_next;
            end
        end
    end

    // stored color and pixel handed to the next cell
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tok_reg <= tok_next;
            cnt_reg <= cnt_next;
            if (take)
            begin
                entry_reg <= tok_in.color;
            end
        end
    end

    assign tok_valid_out = tok_valid_reg;
    assign tok_out       = tok_reg;
    assign cnt_out       = cnt_reg;

endmodule

`default_nettype wire

FILE: hdl/cpi_checker.sv
`default_nettype none

module cpi_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] label,
    input wire logic       new_entry,
    input wire logic       overflow,
    input wire logic [8:0] colors_used
);

    // a refused color neither adds an entry nor carries an index
    a_ovf_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> !new_entry && (label == 8'd0))
        else $error("overflow result with entry or nonzero label");

    // an appended color lands at the end of the palette
    a_new_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && new_entry |-> (colors_used[7:0] == label + 8'd1))
        else $error("new entry label does not match palette size");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(label) && $stable(new_entry)
            && $stable(overflow) && $stable(colors_used))
        else $error("result changed while stalled");

endmodule

bind color_palette_indexer_unit cpi_checker u_cpi_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (lbl.valid),
    .out_ready   (lbl.ready),
    .label       (lbl.label),
    .new_entry   (lbl.new_entry),
    .overflow    (lbl.overflow),
    .colors_used (lbl.colors_used)
);

`default_nettype wire

FILE: test/color_palette_indexer_unit_tb.sv
`default_nettype none

module color_palette_indexer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpi_pkg::*;

    localparam int MAX_COLORS   = 256;
    localparam int LATENCY      = MAX_COLORS + 1;
    localparam int DRAIN_CYCLES = LATENCY + 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 900;
    localparam int PRINT_CAP    = 40;

    // one result as seen on the label channel
    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic               new_entry;
        logic               overflow;
        logic [USED_W-1:0]  colors_used;
    } label_t;

    typedef enum logic {ROW_PIXEL, ROW_LIMIT} row_kind_t;

    // directed stimulus row: a pixel or a limit write
    typedef struct {
        row_kind_t          kind;
        logic [LIMIT_W-1:0] limit;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  red;
        logic               is_first;
        logic               typed;
        label_t             want;
    } stim_row_t;

    localparam label_t NO_LABEL = '0;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [LIMIT_W-1:0]  cfg_wdata;

    cpi_pixel_if pix_if ();
    cpi_label_if lbl_if ();

    color_palette_indexer_unit #(
        .MAX_COLORS (MAX_COLORS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix_if),
        .lbl       (lbl_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // palette tracking for label prediction
    logic [COLOR_W-1:0]  pal_colors [MAX_COLORS];
    int                  pal_count;
    logic [LIMIT_W-1:0]  pal_limit;

    label_t              pending_labels [$];
    stim_row_t           directed_rows [$];

    int mismatch_count;
    int cycle_count;
    int random_sent;
    int src_idle_pct;
    int snk_idle_pct;
    int labels_seen;
    int image_count;
    int hit_count;
    int add_count;
    int ovf_count;
    int limit_writes;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // label for one pixel, updating the tracked palette
    function automatic label_t index_pixel(input logic [CHAN_W-1:0] b,
                                           input logic [CHAN_W-1:0] g,
                                           input logic [CHAN_W-1:0] r,
                                           input logic is_first);
        label_t             res;
        logic [COLOR_W-1:0] color;
        int                 eff_limit;
        bit                 hit;
        color = {r, g, b};
        res   = NO_LABEL;
        hit   = 1'b0;
        if (is_first)
        begin
            pal_count = 0;
            image_count++;
        end
        // lowest matching entry wins
        for (int i = 0; i < pal_count; i++)
        begin
            if (!hit && pal_colors[i] == color)
            begin
                res.label = LABEL_W'(i);
                hit = 1'b1;
            end
        end
        eff_limit = (int'(pal_limit) > MAX_COLORS) ? MAX_COLORS : int'(pal_limit);
        if (hit)
            hit_count++;
        else if (pal_count < eff_limit)
        begin
            pal_colors[pal_count] = color;
            res.label     = LABEL_W'(pal_count);
            res.new_entry = 1'b1;
            pal_count++;
            add_count++;
        end
        else
        begin
            res.overflow = 1'b1;
            ovf_count++;
        end
        res.colors_used = USED_W'(pal_count);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // one pixel transfer; prediction is made when the transfer happens
    task automatic send_pixel(input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] r, input logic is_first,
                              input bit use_typed, input label_t want);
        label_t predicted;
        // idle mix follows progress through the random part
        if (random_sent < RANDOM_ITEMS / 3)
        begin
            src_idle_pct = 10;
            snk_idle_pct = 84;
        end
        else if (random_sent < 2 * RANDOM_ITEMS / 3)
        begin
            src_idle_pct = 84;
            snk_idle_pct = 10;
        end
        else
        begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
        end
        while ($urandom_range(99) < src_idle_pct)
        begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.blue        <= b;
        pix_if.green       <= g;
        pix_if.red         <= r;
        pix_if.first_pixel <= is_first;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
        predicted = index_pixel(b, g, r, is_first);
        pending_labels.push_back(use_typed ? want : predicted);
    endtask

    // hold off the sender until every pending label has come back
    task automatic wait_drain();
        pix_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_labels.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_limit(input logic [LIMIT_W-1:0] value);
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        pal_limit = value;
        limit_writes++;
        @(posedge clk);
    endtask

    // one image drawn mostly from a small pool of colors
    task automatic run_image(input int len, input int pool_n);
        logic [COLOR_W-1:0] pool [$];
        logic [COLOR_W-1:0] c;
        logic               is_first;
        for (int i = 0; i < pool_n; i++)
        begin
            c = COLOR_W'($urandom);
            // near neighbors to exercise exact matching
            if (i > 0 && $urandom_range(3) == 0)
                c = pool[i-1] ^ (COLOR_W'(1) << $urandom_range(COLOR_W - 1));
            pool.push_back(c);
        end
        for (int n = 0; n < len; n++)
        begin
            if ($urandom_range(9) == 0)
                c = COLOR_W'($urandom);
            else
                c = pool[$urandom_range(pool_n - 1)];
            if (n == 0)
                is_first = ($urandom_range(19) != 0);
            else
                is_first = ($urandom_range(49) == 0);
            send_pixel(c[7:0], c[15:8], c[23:16], is_first, 1'b0, NO_LABEL);
            random_sent++;
            if ($urandom_range(199) == 0)
                wait_drain();
        end
    endtask

    // label receiver stalls
    always @(posedge clk)
        lbl_if.ready <= ($urandom_range(99) >= snk_idle_pct);

    // compare each label transfer with the oldest prediction
    always @(posedge clk)
    begin : check_labels
        label_t want;
        if (rst_n && lbl_if.valid && lbl_if.ready)
        begin
            labels_seen++;
            if (pending_labels.size() == 0)
                report_mismatch("label transfer with no pixel pending");
            else
            begin
                want = pending_labels.pop_front();
                if (lbl_if.label !== want.label)
                    report_mismatch($sformatf("label %0d, want %0d",
                                              lbl_if.label, want.label));
                if (lbl_if.new_entry !== want.new_entry)
                    report_mismatch($sformatf("new_entry %b, want %b",
                                              lbl_if.new_entry, want.new_entry));
                if (lbl_if.overflow !== want.overflow)
                    report_mismatch($sformatf("overflow %b, want %b",
                                              lbl_if.overflow, want.overflow));
                if (lbl_if.colors_used !== want.colors_used)
                    report_mismatch($sformatf("colors_used %0d, want %0d",
                                              lbl_if.colors_used, want.colors_used));
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d labels pending",
                     cycle_count, pending_labels.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        logic [COLOR_W-1:0] sweep [$];
        logic [COLOR_W-1:0] c;
        bit                 long_done;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        pix_if.valid       = 1'b0;
        pix_if.blue        = '0;
        pix_if.green       = '0;
        pix_if.red         = '0;
        pix_if.first_pixel = 1'b0;
        lbl_if.ready       = 1'b0;
        src_idle_pct       = 10;
        snk_idle_pct       = 84;
        pal_count          = 0;
        pal_limit          = LIMIT_RESET;
        long_done          = 1'b0;

        // all-zero, all-one, single channels and repeats at the reset limit
        directed_rows.push_back('{ROW_PIXEL, 9'd0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1,
                                  '{8'd0, 1'b1, 1'b0, 9'd1}});
        directed_rows.push_back('{ROW_PIXEL, 9'd0, 8'hff, 8'hff, 8'hff, 1'b0, 1'b1,
                                  '{8'd1, 1'b1, 1'b0, 9'd2}});
        directed_rows.push_back('{ROW_PIXEL, 9'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1,
                                  '{8'd0, 1'b0, 1'b0, 9'd2}});
        directed_rows.push_back('{ROW_PIXEL, 9'd0, 8'hff, 8'h00, 8'h00, 1'b0, 1'b1,
                                  '{8'd2, 1'b1, 1'b0, 9'd3}});
        directed_rows.push_back('{ROW_PIXEL, 9'd0, 8'h00, 8'hff, 8'h00, 1'b0, 1'b1,
                                  '{8'd3, 1'b1, 1'b0, 9'd4}});
        directed_rows.push_back('{ROW_PIXEL, 9'd0, 8'h00, 8'h00, 8'hff, 1'b0, 1'b1,
                                  '{8'd4, 1'b1, 1'b0, 9'd5}});
        directed_rows.push_back('{ROW_PIXEL, 9'd0, 8'hff, 8'hff, 8'hff, 1'b0, 1'b1,
                                  '{8'd1, 1'b0, 1'b0, 9'd5}});
        directed_rows.push_back('{ROW_PIXEL, 9'd0, 8'haa, 8'h55, 8'ha5, 1'b0, 1'b0,
                                  NO_LABEL});
        directed_rows.push_back('{ROW_PIXEL, 9'd0, 8'h55, 8'haa, 8'h5a, 1'b0, 1'b0,
                                  NO_LABEL});
        directed_rows.push_back('{ROW_PIXEL, 9'd0, 8'haa, 8'h55, 8'ha4, 1'b0, 1'b0,
                                  NO_LABEL});
        // new image empties the palette
        directed_rows.push_back('{ROW_PIXEL, 9'd0, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1,
                                  '{8'd0, 1'b1, 1'b0, 9'd1}});
        directed_rows.push_back('{ROW_PIXEL, 9'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1,
                                  '{8'd1, 1'b1, 1'b0, 9'd2}});
        // palette full at a limit of one
        directed_rows.push_back('{ROW_LIMIT, 9'd1, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
                                  NO_LABEL});
        directed_rows.push_back('{ROW_PIXEL, 9'd0, 8'h12, 8'h34, 8'h56, 1'b1, 1'b1,
                                  '{8'd0, 1'b1, 1'b0, 9'd1}});
        directed_rows.push_back('{ROW_PIXEL, 9'd0, 8'h12, 8'h34, 8'h56, 1'b0, 1'b1,
                                  '{8'd0, 1'b0, 1'b0, 9'd1}});
        directed_rows.push_back('{ROW_PIXEL, 9'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1,
                                  '{8'd0, 1'b0, 1'b1, 9'd1}});
        // limit zero refuses every new color
        directed_rows.push_back('{ROW_LIMIT, 9'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
                                  NO_LABEL});
        directed_rows.push_back('{ROW_PIXEL, 9'd0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1,
                                  '{8'd0, 1'b0, 1'b1, 9'd0}});
        directed_rows.push_back('{ROW_PIXEL, 9'd0, 8'hff, 8'hff, 8'hff, 1'b0, 1'b1,
                                  '{8'd0, 1'b0, 1'b1, 9'd0}});
        // limit above storage saturates
        directed_rows.push_back('{ROW_LIMIT, 9'd511, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
                                  NO_LABEL});
        directed_rows.push_back('{ROW_PIXEL, 9'd0, 8'h01, 8'h02, 8'h03, 1'b1, 1'b1,
                                  '{8'd0, 1'b1, 1'b0, 9'd1}});
        // limit lowered mid-image keeps stored entries matching
        directed_rows.push_back('{ROW_LIMIT, 9'd2, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
                                  NO_LABEL});
        directed_rows.push_back('{ROW_PIXEL, 9'd0, 8'h10, 8'h20, 8'h30, 1'b1, 1'b1,
                                  '{8'd0, 1'b1, 1'b0, 9'd1}});
        directed_rows.push_back('{ROW_PIXEL, 9'd0, 8'h40, 8'h50, 8'h60, 1'b0, 1'b1,
                                  '{8'd1, 1'b1, 1'b0, 9'd2}});
        directed_rows.push_back('{ROW_PIXEL, 9'd0, 8'h70, 8'h80, 8'h90, 1'b0, 1'b1,
                                  '{8'd0, 1'b0, 1'b1, 9'd2}});
        directed_rows.push_back('{ROW_LIMIT, 9'd1, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0,
                                  NO_LABEL});
        directed_rows.push_back('{ROW_PIXEL, 9'd0, 8'h40, 8'h50, 8'h60, 1'b0, 1'b1,
                                  '{8'd1, 1'b0, 1'b0, 9'd2}});
        directed_rows.push_back('{ROW_PIXEL, 9'd0, 8'h10, 8'h20, 8'h30, 1'b0, 1'b1,
                                  '{8'd0, 1'b0, 1'b0, 9'd2}});
        directed_rows.push_back('{ROW_PIXEL, 9'd0, 8'h70, 8'h80, 8'h90, 1'b0, 1'b1,
                                  '{8'd0, 1'b0, 1'b1, 9'd2}});

        // reset
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (directed_rows[k])
        begin
            if (directed_rows[k].kind == ROW_LIMIT)
                set_limit(directed_rows[k].limit);
            else
                send_pixel(directed_rows[k].blue, directed_rows[k].green,
                           directed_rows[k].red, directed_rows[k].is_first,
                           directed_rows[k].typed, directed_rows[k].want);
        end

        // random part: a limit setting, then a few images under it
        while (random_sent < RANDOM_ITEMS)
        begin
            if (!long_done && random_sent >= 350)
            begin
                // more distinct colors than the palette can hold
                set_limit(9'd256);
                sweep.delete();
                for (int i = 0; i < 300; i++)
                    sweep.push_back({9'(i), 15'($urandom_range(32767))});
                for (int n = 0; n < 320; n++)
                begin
                    c = (n < 300) ? sweep[n] : sweep[$urandom_range(299)];
                    send_pixel(c[7:0], c[15:8], c[23:16], n == 0, 1'b0, NO_LABEL);
                    random_sent++;
                end
                long_done = 1'b1;
            end
            else
            begin
                case ($urandom_range(9))
                    0: set_limit(9'd1);
                    1: set_limit(9'd2);
                    2: set_limit(9'd3);
                    3: set_limit(9'd8);
                    4: set_limit(9'd16);
                    5: set_limit(9'd255);
                    6: set_limit(9'd256);
                    7: set_limit(($urandom_range(7) == 0) ? 9'd0 : 9'd511);
                    default: set_limit(LIMIT_W'($urandom_range(511)));
                endcase
                repeat ($urandom_range(1, 3))
                    run_image($urandom_range(4, 40), $urandom_range(1, 24));
            end
        end

        // wait for the last labels, then watch for stray transfers
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d pixels over %0d images and %0d limit settings",
                 labels_seen, image_count, limit_writes);
        $display("palette outcomes: %0d hits, %0d new entries, %0d overflows",
                 hit_count, add_count, ovf_count);
        if (mismatch_count == 0 && pending_labels.size() == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches, %0d labels missing",
                     mismatch_count, pending_labels.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
hdl/cpi_pkg.sv
hdl/cpi_ifs.sv
hdl/cpi_cell.sv
hdl/color_palette_indexer_unit.sv
hdl/cpi_checker.sv
test/color_palette_indexer_unit_tb.sv
